@@ hw/rtl/gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Gradient color map package
// Shared constants and types for the gradient color map pipeline.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int MAX_STOPS     = 7;
  localparam int FRACTION_BITS = 16;

  localparam int NUM_STOPS  = 7;
  localparam int STOP_W     = $clog2(NUM_STOPS + 1);
  localparam int LEVEL_W    = FRACTION_BITS + 2;
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 3 * CHAN_W;
  localparam int WEIGHT_W   = FRACTION_BITS + 1;
  localparam int PROD_W     = CHAN_W + WEIGHT_W;
  localparam int SCALED_W   = FRACTION_BITS + STOP_W;
  localparam int SIZE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COLOR_0  = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0]  GRADIENT_SIZE_RESET = SIZE_W'(2);
  localparam logic [COLOR_W-1:0] STOP_1_RESET        = {COLOR_W{1'b1}};

  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;

  typedef struct packed {
    logic prod;
    logic sum;
  } blend_en_t;

endpackage

@@ hw/rtl/gcm_blend.sv @@
// ----------------------------------------------------------------------------
// Gradient color map blend
// Two register stages that mix two stop colors channel by channel: weighted
// products first, then the sum's integer part, truncated to the channel width.
// ----------------------------------------------------------------------------
module gcm_blend (
  input  logic                 clk,
  input  gcm_pkg::blend_en_t   en,
  input  gcm_pkg::color_t      color_lo,
  input  gcm_pkg::color_t      color_hi,
  input  gcm_pkg::frac_t       frac,
  output logic [gcm_pkg::CHAN_W-1:0] red,
  output logic [gcm_pkg::CHAN_W-1:0] green,
  output logic [gcm_pkg::CHAN_W-1:0] blue
);

  logic [gcm_pkg::WEIGHT_W-1:0] weight_lo;
  logic [gcm_pkg::WEIGHT_W-1:0] weight_hi;
  logic [gcm_pkg::PROD_W-1:0]   prod_lo [3];
  logic [gcm_pkg::PROD_W-1:0]   prod_hi [3];
  logic [gcm_pkg::PROD_W-1:0]   mix     [3];
  logic [gcm_pkg::CHAN_W-1:0]   chan    [3];

  assign weight_hi = {1'b0, frac};
  assign weight_lo = (gcm_pkg::WEIGHT_W'(1) << gcm_pkg::FRACTION_BITS) - weight_hi;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int c = 0; c < 3; c++) begin
        prod_lo[c] <= gcm_pkg::PROD_W'(color_lo[c*gcm_pkg::CHAN_W +: gcm_pkg::CHAN_W])
                      * gcm_pkg::PROD_W'(weight_lo);
        prod_hi[c] <= gcm_pkg::PROD_W'(color_hi[c*gcm_pkg::CHAN_W +: gcm_pkg::CHAN_W])
                      * gcm_pkg::PROD_W'(weight_hi);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mix[c] = prod_lo[c] + prod_hi[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      for (int c = 0; c < 3; c++) begin
        chan[c] <= mix[c][gcm_pkg::FRACTION_BITS +: gcm_pkg::CHAN_W];
      end
    end
  end

  assign blue  = chan[0];
  assign green = chan[1];
  assign red   = chan[2];

endmodule

@@ hw/rtl/gradient_color_map_core.sv @@
// ----------------------------------------------------------------------------
// Gradient color map core
// Maps a signed fixed-point level to an RGB color through a linear gradient.
// ----------------------------------------------------------------------------
// The core takes one level per clock unless a stall holds the input, and
// returns one color per level through a four-stage pipeline: stop selection,
// stop color fetch, weighted products and the final sum. Each stage advances
// on its own when the next one has room, so a stall on the output fills
// empty stages before it holds the input. Write the gradient size and stop
// colors only while no level is in flight.
// ----------------------------------------------------------------------------
module gradient_color_map_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [gcm_pkg::CFG_IDX_W-1:0]       write_index,
  input  logic [gcm_pkg::CFG_DATA_W-1:0]      write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [gcm_pkg::LEVEL_W-1:0]  level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gcm_pkg::CHAN_W-1:0]          red,
  output logic [gcm_pkg::CHAN_W-1:0]          green,
  output logic [gcm_pkg::CHAN_W-1:0]          blue
);

  logic [gcm_pkg::SIZE_W-1:0] gradient_size;
  gcm_pkg::color_t            stop_color [gcm_pkg::NUM_STOPS];

  logic [gcm_pkg::STOP_W-1:0]   stops;
  logic [gcm_pkg::STOP_W-1:0]   lo_next;
  logic [gcm_pkg::STOP_W-1:0]   hi_next;
  gcm_pkg::frac_t               frac_next;
  logic [gcm_pkg::SCALED_W-1:0] scaled;
  logic [gcm_pkg::STOP_W-1:0]   ip;
  logic                         below;
  logic                         above;

  logic [gcm_pkg::STOP_W-1:0] lo;
  logic [gcm_pkg::STOP_W-1:0] hi;
  gcm_pkg::frac_t             frac1;
  gcm_pkg::color_t            color_lo;
  gcm_pkg::color_t            color_hi;
  gcm_pkg::frac_t             frac2;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  gcm_pkg::blend_en_t blend_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_size <= gcm_pkg::GRADIENT_SIZE_RESET;
      for (int i = 0; i < gcm_pkg::NUM_STOPS; i++) begin
        stop_color[i] <= (i == 1) ? gcm_pkg::STOP_1_RESET : '0;
      end
    end else if (write_enable) begin
      if (write_index == gcm_pkg::REG_GRADIENT_SIZE) begin
        gradient_size <= write_data[gcm_pkg::SIZE_W-1:0];
      end else begin
        for (int i = 0; i < gcm_pkg::NUM_STOPS; i++) begin
          if (write_index == gcm_pkg::REG_STOP_COLOR_0 + gcm_pkg::CFG_IDX_W'(i)) begin
            stop_color[i] <= write_data[gcm_pkg::COLOR_W-1:0];
          end
        end
      end
    end
  end

  // Handshake: each stage loads when it is empty or its successor moves.
  assign en4      = !v4 || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign out_valid = v4;
  assign blend_en.prod = en3;
  assign blend_en.sum  = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_comb begin
    if (gradient_size < gcm_pkg::STOP_W'(2)) begin
      stops = gcm_pkg::STOP_W'(2);
    end else if (gradient_size > gcm_pkg::STOP_W'(gcm_pkg::MAX_STOPS)) begin
      stops = gcm_pkg::STOP_W'(gcm_pkg::MAX_STOPS);
    end else begin
      stops = gradient_size;
    end

    below  = level[gcm_pkg::LEVEL_W-1] || (level == '0);
    above  = level[gcm_pkg::FRACTION_BITS];
    scaled = gcm_pkg::SCALED_W'(level[gcm_pkg::FRACTION_BITS-1:0])
             * gcm_pkg::SCALED_W'(stops - gcm_pkg::STOP_W'(1));
    ip     = scaled[gcm_pkg::FRACTION_BITS +: gcm_pkg::STOP_W];
    if (ip > stops - gcm_pkg::STOP_W'(2)) begin
      ip = stops - gcm_pkg::STOP_W'(2);
    end

    if (below) begin
      lo_next   = '0;
      hi_next   = '0;
      frac_next = '0;
    end else if (above) begin
      lo_next   = stops - gcm_pkg::STOP_W'(1);
      hi_next   = stops - gcm_pkg::STOP_W'(1);
      frac_next = '0;
    end else begin
      lo_next   = ip;
      hi_next   = ip + gcm_pkg::STOP_W'(1);
      frac_next = scaled[gcm_pkg::FRACTION_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      lo    <= lo_next;
      hi    <= hi_next;
      frac1 <= frac_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      color_lo <= stop_color[lo];
      color_hi <= stop_color[hi];
      frac2    <= frac1;
    end
  end

  gcm_blend u_blend (
    .clk      (clk),
    .en       (blend_en),
    .color_lo (color_lo),
    .color_hi (color_hi),
    .frac     (frac2),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Gradient color map core testbench
// Sends signed Q2.16 levels through the core under random input bursts and
// output stalls. A scoreboard keeps its own copy of the gradient registers,
// works out the blended color of every level that is taken in, and compares
// the red, green and blue channels of each returned color in order. The run
// steps through several gradient sizes and stop color sets, the extremes
// among them.
// ----------------------------------------------------------------------------
module tb_top;
  import gcm_pkg::*;

  localparam int ONE_LEVEL = 1 << FRACTION_BITS;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct {
    level_t level;
    color_t color;
  } queued_color_t;

  class color_scoreboard;
    logic [SIZE_W-1:0] size_reg;
    color_t            stop_reg [NUM_STOPS];
    queued_color_t     color_q [$];
    int                errors;

    function new();
      size_reg = GRADIENT_SIZE_RESET;
      foreach (stop_reg[k]) stop_reg[k] = '0;
      stop_reg[1] = STOP_1_RESET;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_GRADIENT_SIZE) begin
        size_reg = data[SIZE_W-1:0];
      end else begin
        stop_reg[int'(idx) - int'(REG_STOP_COLOR_0)] = data[COLOR_W-1:0];
      end
    endfunction

    function color_t blend_level(level_t lv);
      int unsigned       n;
      int unsigned       lo;
      int unsigned       hi;
      longint unsigned   scaled;
      longint unsigned   weight;
      longint unsigned   a;
      longint unsigned   b;
      longint unsigned   mix;
      color_t            res;
      n = 32'(size_reg);
      if (n < 2) n = 2;
      if (n > MAX_STOPS) n = MAX_STOPS;
      weight = 0;
      if (lv <= 0) begin
        lo = 0;
        hi = 0;
      end else if (lv >= ONE_LEVEL) begin
        lo = n - 1;
        hi = n - 1;
      end else begin
        scaled = longint'(lv) * (n - 1);
        lo = 32'(scaled >> FRACTION_BITS);
        if (lo > n - 2) lo = n - 2;
        hi = lo + 1;
        weight = scaled & (ONE_LEVEL - 1);
      end
      for (int ch = 0; ch < 3; ch++) begin
        a = 64'(stop_reg[lo][CHAN_W*ch +: CHAN_W]);
        b = 64'(stop_reg[hi][CHAN_W*ch +: CHAN_W]);
        mix = (b * weight + a * (ONE_LEVEL - weight)) >> FRACTION_BITS;
        res[CHAN_W*ch +: CHAN_W] = mix[CHAN_W-1:0];
      end
      return res;
    endfunction

    function void note_level(level_t lv);
      queued_color_t e;
      e.level = lv;
      e.color = blend_level(lv);
      color_q.push_back(e);
    endfunction

    function void check_color(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b);
      queued_color_t e;
      if (color_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected color r=%02h g=%02h b=%02h", r, g, b);
        return;
      end
      e = color_q.pop_front();
      if (r !== e.color[23:16] || g !== e.color[15:8] || b !== e.color[7:0]) begin
        errors++;
        if (errors <= 10)
          $display("level %0d: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                   e.level, e.color[23:16], e.color[15:8], e.color[7:0], r, g, b);
      end
    endfunction

    function int pending();
      return color_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  write_index = '0;
  logic [CFG_DATA_W-1:0] write_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  level_t                level = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAN_W-1:0]     red;
  logic [CHAN_W-1:0]     green;
  logic [CHAN_W-1:0]     blue;

  color_scoreboard sb = new();
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  gradient_color_map_core dut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .level(level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_color(red, green, blue);
      if (in_valid && !in_stall) sb.note_level(level);
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic write_gradient(int unsigned size, int scheme);
    logic [CFG_DATA_W-1:0] c;
    write_reg(REG_GRADIENT_SIZE, CFG_DATA_W'(($urandom & 24'hFFFFF8) | (size & 7)));
    for (int k = 0; k < NUM_STOPS; k++) begin
      case (scheme)
        0: c = CFG_DATA_W'($urandom);
        1: c = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        default: c = (k % 2) ? 24'h000000 : 24'hFFFFFF;
      endcase
      write_reg(CFG_IDX_W'(int'(REG_STOP_COLOR_0) + k), c);
    end
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic send_level(level_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    level    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic level_t pick_level();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return level_t'($urandom_range(1, ONE_LEVEL - 1));
    if (sel < 78) return level_t'(-$urandom_range(1, 131072));
    if (sel < 86) return level_t'($urandom_range(ONE_LEVEL, 131071));
    if (sel < 90) return '0;
    return level_t'($urandom);
  endfunction

  initial begin
    static int unsigned sizes [9] = '{0, 1, 7, 3, 4, 5, 6, 2, 7};
    static level_t reset_levels [12] = '{-131072, -65536, -1, 0, 1, 2, 32767, 32768,
                                         65535, 65536, 65537, 131071};
    static level_t seven_levels [8] = '{1, 10922, 10923, 21846, 43690, 54613, 54614,
                                        65535};
    static logic [CFG_DATA_W-1:0] seven_colors [7] = '{24'hFF0000, 24'h00FF00,
                                                       24'h0000FF, 24'hFFFFFF,
                                                       24'h000000, 24'h808080,
                                                       24'h123456};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (reset_levels[k]) send_level(reset_levels[k]);
    drain();

    write_reg(REG_GRADIENT_SIZE, 24'h000007);
    foreach (seven_colors[k]) write_reg(CFG_IDX_W'(int'(REG_STOP_COLOR_0) + k),
                                        seven_colors[k]);
    @(negedge clk);
    write_enable <= 1'b0;
    foreach (seven_levels[k]) send_level(seven_levels[k]);
    drain();

    foreach (sizes[p]) begin
      write_gradient(sizes[p], p % 3);
      repeat (105) send_level(pick_level());
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
